[sv/ila_pkg.sv]
// Shared types, constants and helper functions for the interval lane assigner.
// No dependencies; imported by ila_store, ila_seq and interval_lane_assigner.
package ila_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam int TIME_W  = 24;
  localparam int LANE_W  = 6;
  localparam int BOX_W   = 8;
  localparam int Y_W     = 15;
  localparam int GRP_W   = 8;                 // lanes looked at per search step
  localparam int NGRP    = (1 << LANE_W) / GRP_W;
  localparam int GSEL_W  = $clog2(NGRP);
  localparam int BIT_W   = $clog2(GRP_W);

  localparam logic [BOX_W-1:0] BOX_HEIGHT_RST = 8'd20;
  localparam logic [BOX_W-1:0] BOX_GAP_RST    = 8'd3;

  typedef enum logic {
    REG_BOX_HEIGHT = 1'b0,
    REG_BOX_GAP    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEARCH,
    ST_STORE,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] finish;
    logic [LANE_W-1:0] lane;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  // Position of the lowest clear bit; all ones gives the top position.
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [GRP_W-1:0] v);
    logic [BIT_W-1:0] pos;
    pos = BIT_W'(GRP_W - 1);
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (!v[b]) pos = BIT_W'(b);
    end
    return pos;
  endfunction

endpackage

[sv/interval_lane_assigner.sv]
// Top level of the interval lane assigner: box registers, store and sequencer.
// Depends on ila_pkg, ila_store and ila_seq.
//
//   channel  | handshake          | fields
//   ---------+--------------------+-------------------------------------------
//   item in  | start & !busy      | new_set, start_time, finish_time
//   result   | done (one cycle)   | lane, highest_lane_seen, y_top, y_bottom,
//            |                    | overflow
//   config   | cfg_we             | cfg_index, cfg_data
//
// An item runs through scan, free-lane search, store and emit from its accepting edge
// to the result beat: the scan reads one store entry per cycle and then drains the
// last read, the free-lane search takes one to eight steps of eight lanes, then store,
// product and sum. busy drops in the done cycle, so the next beat can be taken at the
// edge that ends the result beat, which the receiver cannot stall. Reset empties the
// set and loads box_height 20 and box_gap 3.
module interval_lane_assigner
  import ila_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              new_set,
  input  logic [TIME_W-1:0] start_time,
  input  logic [TIME_W-1:0] finish_time,
  output logic              done,
  output logic [LANE_W-1:0] lane,
  output logic [LANE_W-1:0] highest_lane_seen,
  output logic [Y_W-1:0]    y_top,
  output logic [Y_W-1:0]    y_bottom,
  output logic              overflow,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BOX_W-1:0]  cfg_data
);

  logic [BOX_W-1:0] box_height;
  logic [BOX_W-1:0] box_gap;
  mem_req_t         req;
  entry_t           rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_height <= BOX_HEIGHT_RST;
      box_gap    <= BOX_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOX_HEIGHT: box_height <= cfg_data;
        REG_BOX_GAP:    box_gap    <= cfg_data;
        default: ;
      endcase
    end
  end

  ila_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  ila_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .new_set           (new_set),
    .start_time        (start_time),
    .finish_time       (finish_time),
    .box_height        (box_height),
    .box_gap           (box_gap),
    .rd_data           (rd_data),
    .req               (req),
    .busy              (busy),
    .done              (done),
    .lane              (lane),
    .highest_lane_seen (highest_lane_seen),
    .y_top             (y_top),
    .y_bottom          (y_bottom),
    .overflow          (overflow)
  );

endmodule

[sv/ila_store.sv]
// Interval store: finish time and lane per stored interval, one write and
// one registered read per cycle. Depends on ila_pkg.
module ila_store
  import ila_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end

endmodule

[sv/ila_seq.sv]
// Sequencer: scans the store one entry a cycle into a busy-lane mask, finds the
// lowest free lane eight lanes a step, stores the item and forms the box extent.
// Depends on ila_pkg.
module ila_seq
  import ila_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              new_set,
  input  logic [TIME_W-1:0] start_time,
  input  logic [TIME_W-1:0] finish_time,
  input  logic [BOX_W-1:0]  box_height,
  input  logic [BOX_W-1:0]  box_gap,
  input  entry_t            rd_data,
  output mem_req_t          req,
  output logic              busy,
  output logic              done,
  output logic [LANE_W-1:0] lane,
  output logic [LANE_W-1:0] highest_lane_seen,
  output logic [Y_W-1:0]    y_top,
  output logic [Y_W-1:0]    y_bottom,
  output logic              overflow
);

  seq_state_t state, state_next;

  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic              pend;
  logic [GSEL_W-1:0] grp;
  logic [TIME_W-1:0] start_q;
  logic [TIME_W-1:0] finish_q;
  logic [LANE_W-1:0] highest;
  logic [NGRP-1:0][GRP_W-1:0] mask;

  logic              rd_go;
  logic              has_room;
  logic [GRP_W-1:0]  chunk;
  logic              found;
  logic [BOX_W:0]    pitch;
  logic [Y_W-1:0]    prod;

  assign rd_go    = (state == ST_SCAN) && (idx < count);
  assign has_room = count < CNT_W'(MAX_ITEMS);
  assign chunk    = mask[grp];
  assign found    = (chunk != '1) || (grp == GSEL_W'(NGRP - 1));
  assign pitch    = {1'b0, box_height} + {1'b0, box_gap};
  assign prod     = Y_W'({{(Y_W-LANE_W){1'b0}}, lane} * {{(Y_W-BOX_W-1){1'b0}}, pitch});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (!rd_go && !pend) state_next = ST_SEARCH;
      ST_SEARCH: if (found) state_next = ST_STORE;
      ST_STORE:  state_next = ST_EMIT;
      ST_EMIT:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.rd_en          = rd_go;
    req.rd_addr        = idx[ADDR_W-1:0];
    req.wr_en          = (state == ST_STORE) && has_room;
    req.wr_addr        = count[ADDR_W-1:0];
    req.wr_data.finish = finish_q;
    req.wr_data.lane   = lane;
    busy               = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      highest <= '0;
      pend    <= 1'b0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EMIT);
      pend  <= rd_go;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            start_q  <= start_time;
            finish_q <= finish_time;
            idx      <= '0;
            grp      <= '0;
            mask     <= '0;
            if (new_set) begin
              count   <= '0;
              highest <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (rd_go) idx <= idx + 1'b1;
          // read beat lands in the cycle after its address
          if (pend && (start_q < rd_data.finish)) mask[rd_data.lane[LANE_W-1:BIT_W]]
              [rd_data.lane[BIT_W-1:0]] <= 1'b1;
        end
        ST_SEARCH: begin
          if (found) lane <= {grp, lowest_zero(chunk)};
          else grp <= grp + 1'b1;
        end
        ST_STORE: begin
          overflow          <= !has_room;
          if (has_room) count <= count + 1'b1;
          highest           <= (lane > highest) ? lane : highest;
          highest_lane_seen <= (lane > highest) ? lane : highest;
          y_top             <= prod;
        end
        ST_EMIT: begin
          y_bottom <= y_top + {{(Y_W-BOX_W){1'b0}}, box_height};
        end
        default: ;
      endcase
    end
  end

endmodule
